// ===== hw/rtl/swac_pkg.sv =====
// Shared types and constants for the sensor window averager and converter.
// No dependencies; used by swac_convert and sensor_window_average_convert.

package swac_pkg;

  // Averaging window. The average is the top bits of the window sum.
  localparam int unsigned Window   = 64;
  localparam int unsigned WinShift = 6;
  localparam int unsigned AvgW     = 8;
  localparam int unsigned SumW     = AvgW + WinShift;
  localparam int unsigned LeftW    = WinShift + 1;

  // Temperature segments.
  localparam logic [AvgW-1:0] TempZeroAbove = 8'd188;
  localparam logic [AvgW-1:0] TempSatBelow  = 8'd82;
  localparam logic [AvgW-1:0] TempSatValue  = 8'd46;
  localparam logic [AvgW-1:0] TempSegSplit  = 8'd104;
  localparam logic [15:0]     TempHiBase    = 16'd4608;
  localparam logic [AvgW-1:0] TempHiPivot   = 8'd145;
  localparam logic [6:0]      TempHiSlope   = 7'd104;
  localparam logic [15:0]     TempLoBase    = 16'd10522;
  localparam logic [AvgW-1:0] TempLoPivot   = 8'd91;
  localparam logic [6:0]      TempLoSlope   = 7'd125;
  localparam logic [15:0]     TempRound     = 16'd128;

  // Humidity in Q8.24: 1/1.816685534 and 4.468284738, both scaled by 2^24.
  localparam logic [23:0] HumRecip  = 24'd9235069;
  localparam logic [26:0] HumOffset = 27'd74965378;

  typedef enum logic [1:0] {
    CFG_TEMP_LOW  = 2'd0,
    CFG_TEMP_HIGH = 2'd1,
    CFG_HUM_LOW   = 2'd2,
    CFG_HUM_HIGH  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RPT_NONE  = 2'd0,
    RPT_RAISE = 2'd1,
    RPT_CLEAR = 2'd2
  } report_e;

  typedef enum logic {
    ACT_ADD     = 1'b0,
    ACT_RESTART = 1'b1
  } action_e;

  typedef enum logic {
    CH_TEMP = 1'b0,
    CH_HUM  = 1'b1
  } channel_e;

  // A closed window waiting for conversion and range check.
  typedef struct packed {
    channel_e        channel;
    logic [AvgW-1:0] avg;
    logic            quiet;
  } window_t;

endpackage

// ===== hw/rtl/swac_convert.sv =====
// Converts a window average to degrees Celsius or percent humidity.
// Purely combinational; uses swac_pkg for constants and types.

module swac_convert (
  input  swac_pkg::channel_e              channel_i,
  input  logic [swac_pkg::AvgW-1:0]       avg_i,
  output logic [swac_pkg::AvgW-1:0]       converted_o
);

  logic [swac_pkg::AvgW-1:0] pivot;
  logic [15:0]               base;
  logic [6:0]                slope;
  logic                      above;
  logic [swac_pkg::AvgW-1:0] diff;
  logic [14:0]               prod;
  logic [15:0]               seg_val;
  logic [15:0]               rounded;
  logic [swac_pkg::AvgW-1:0] celsius;
  logic [32:0]               hum_acc;

  always_comb begin
    if (avg_i > swac_pkg::TempSegSplit) begin
      pivot = swac_pkg::TempHiPivot;
      base  = swac_pkg::TempHiBase;
      slope = swac_pkg::TempHiSlope;
    end else begin
      pivot = swac_pkg::TempLoPivot;
      base  = swac_pkg::TempLoBase;
      slope = swac_pkg::TempLoSlope;
    end
    above   = avg_i > pivot;
    diff    = above ? (avg_i - pivot) : (pivot - avg_i);
    prod    = 15'(diff) * 15'(slope);
    // Within the linear range the segment value stays inside 16 bits.
    seg_val = above ? (base - 16'(prod)) : (base + 16'(prod));
    rounded = seg_val + swac_pkg::TempRound;

    if (avg_i > swac_pkg::TempZeroAbove) begin
      celsius = '0;
    end else if (avg_i < swac_pkg::TempSatBelow) begin
      celsius = swac_pkg::TempSatValue;
    end else begin
      celsius = rounded[15:8];
    end
  end

  assign hum_acc = 33'(avg_i) * 33'(swac_pkg::HumRecip) + 33'(swac_pkg::HumOffset);

  assign converted_o = (channel_i == swac_pkg::CH_HUM) ? hum_acc[31:24] : celsius;

endmodule

// ===== hw/rtl/sensor_window_average_convert.sv =====
// A sample that closes a window passes the window register, then the result register.
// Throughput: one request per cycle while in_stall_o is low; sums and counters update in
// the accepting cycle; conversion and range check run between window and result registers.
// Reset (async, active low) clears both sums, loads both counters with the window length,
// clears the abnormal flag and loads the limit registers with their defaults.
// Depends on swac_pkg and swac_convert.

module sensor_window_average_convert (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic       channel_i,
  input  logic [7:0] sample_i,
  input  logic       quiet_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       which_channel_o,
  output logic [7:0] average_o,
  output logic [7:0] converted_o,
  output logic       checked_o,
  output logic       abnormal_o,
  output logic [1:0] error_report_o
);

  localparam int unsigned SumW  = swac_pkg::SumW;
  localparam int unsigned LeftW = swac_pkg::LeftW;
  localparam int unsigned AvgW  = swac_pkg::AvgW;

  // Configuration registers.
  logic [7:0] temp_low_q, temp_high_q, hum_low_q, hum_high_q;

  // Window state.
  logic [SumW-1:0]  temp_sum_q, temp_sum_d, hum_sum_q, hum_sum_d;
  logic [LeftW-1:0] temp_left_q, temp_left_d, hum_left_q, hum_left_d;

  // Closed-window stage and result stage.
  logic                 win_valid_q, win_valid_d;
  swac_pkg::window_t    win_q, win_d;
  logic                 out_valid_q, out_valid_d;
  logic                 abnormal_q, abnormal_d;
  logic                 out_chan_q;
  logic [AvgW-1:0]      out_avg_q, out_conv_q;
  logic                 out_checked_q, out_checked_d;
  swac_pkg::report_e    out_rpt_q, out_rpt_d;

  logic             in_accept, res_ready, win_move;
  logic             is_hum;
  logic [SumW-1:0]  cur_sum, new_sum;
  logic [LeftW-1:0] cur_left, eff_left, new_left;
  logic             closes;
  logic [AvgW-1:0]  conv;
  logic [7:0]       lim_lo, lim_hi;
  logic             out_of_range;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_low_q  <= 8'd27;
      temp_high_q <= 8'd245;
      hum_low_q   <= 8'd4;
      hum_high_q  <= 8'd204;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (swac_pkg::cfg_idx_e'(cfg_index_i))
        swac_pkg::CFG_TEMP_LOW:  temp_low_q  <= cfg_data_i;
        swac_pkg::CFG_TEMP_HIGH: temp_high_q <= cfg_data_i;
        swac_pkg::CFG_HUM_LOW:   hum_low_q   <= cfg_data_i;
        swac_pkg::CFG_HUM_HIGH:  hum_high_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees when empty or taken this cycle.
  assign res_ready  = !out_valid_q || !out_stall_i;
  assign win_move   = win_valid_q && res_ready;
  assign in_stall_o = win_valid_q && !res_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Accumulate stage.
  always_comb begin
    is_hum   = (channel_i == swac_pkg::CH_HUM);
    cur_sum  = is_hum ? hum_sum_q : temp_sum_q;
    cur_left = is_hum ? hum_left_q : temp_left_q;
    new_sum  = cur_sum + SumW'(sample_i);
    // A counter outside 1..Window behaves as one sample left.
    if (cur_left == '0 || cur_left > LeftW'(swac_pkg::Window)) begin
      eff_left = LeftW'(1);
    end else begin
      eff_left = cur_left;
    end
    new_left = eff_left - LeftW'(1);
    closes   = (new_left == '0);

    temp_sum_d  = temp_sum_q;
    temp_left_d = temp_left_q;
    hum_sum_d   = hum_sum_q;
    hum_left_d  = hum_left_q;
    win_d       = win_q;
    win_valid_d = win_move ? 1'b0 : win_valid_q;

    if (in_accept) begin
      if (action_i == swac_pkg::ACT_RESTART) begin
        temp_sum_d  = '0;
        hum_sum_d   = '0;
        temp_left_d = LeftW'(swac_pkg::Window);
        hum_left_d  = LeftW'(swac_pkg::Window);
      end else begin
        if (is_hum) begin
          hum_sum_d  = closes ? '0 : new_sum;
          hum_left_d = closes ? LeftW'(swac_pkg::Window) : new_left;
        end else begin
          temp_sum_d  = closes ? '0 : new_sum;
          temp_left_d = closes ? LeftW'(swac_pkg::Window) : new_left;
        end
        if (closes) begin
          win_valid_d   = 1'b1;
          win_d.channel = swac_pkg::channel_e'(channel_i);
          win_d.avg     = new_sum[SumW-1:SumW-AvgW];
          win_d.quiet   = quiet_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_sum_q  <= '0;
      hum_sum_q   <= '0;
      temp_left_q <= LeftW'(swac_pkg::Window);
      hum_left_q  <= LeftW'(swac_pkg::Window);
      win_valid_q <= 1'b0;
    end else begin
      temp_sum_q  <= temp_sum_d;
      hum_sum_q   <= hum_sum_d;
      temp_left_q <= temp_left_d;
      hum_left_q  <= hum_left_d;
      win_valid_q <= win_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // Conversion and range check stage.
  swac_convert u_convert (
    .channel_i   (win_q.channel),
    .avg_i       (win_q.avg),
    .converted_o (conv)
  );

  always_comb begin
    lim_lo = (win_q.channel == swac_pkg::CH_HUM) ? hum_low_q  : temp_low_q;
    lim_hi = (win_q.channel == swac_pkg::CH_HUM) ? hum_high_q : temp_high_q;
    out_of_range = (win_q.avg <= lim_lo) || (win_q.avg >= lim_hi);

    abnormal_d    = abnormal_q;
    out_checked_d = 1'b0;
    out_rpt_d     = swac_pkg::RPT_NONE;
    if (!win_q.quiet) begin
      out_checked_d = 1'b1;
      if (out_of_range) begin
        abnormal_d = 1'b1;
        out_rpt_d  = swac_pkg::RPT_RAISE;
      end else begin
        abnormal_d = 1'b0;
        out_rpt_d  = abnormal_q ? swac_pkg::RPT_CLEAR : swac_pkg::RPT_NONE;
      end
    end

    if (win_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      abnormal_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (win_move) begin
        abnormal_q <= abnormal_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_move) begin
      out_chan_q    <= win_q.channel;
      out_avg_q     <= win_q.avg;
      out_conv_q    <= conv;
      out_checked_q <= out_checked_d;
      out_rpt_q     <= out_rpt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign which_channel_o = out_chan_q;
  assign average_o       = out_avg_q;
  assign converted_o     = out_conv_q;
  assign checked_o       = out_checked_q;
  assign abnormal_o      = abnormal_q;
  assign error_report_o  = out_rpt_q;

  // A shown raise report always comes with the flag set, a recovery with it clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rpt_q == swac_pkg::RPT_RAISE) |-> abnormal_q)
    else $error("raise report without abnormal flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rpt_q == swac_pkg::RPT_CLEAR) |-> !abnormal_q)
    else $error("recovery report with abnormal flag set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_checked_q) |-> (out_rpt_q == swac_pkg::RPT_NONE))
    else $error("report given on an unchecked window");

  // Counters stay inside one window length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (temp_left_q != '0 && temp_left_q <= LeftW'(swac_pkg::Window) &&
     hum_left_q != '0 && hum_left_q <= LeftW'(swac_pkg::Window)))
    else $error("window counter out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && action_i == swac_pkg::ACT_RESTART) |=>
      (temp_sum_q == '0 && hum_sum_q == '0))
    else $error("restart did not clear the window sums");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for sensor_window_average_convert.
// Depends on swac_pkg and the block's RTL; a local model predicts each closed window
// and the checker compares every result field against it.

module tb;

  localparam int unsigned WINDOW_LEN   = 64;
  localparam int unsigned STUCK_LIMIT  = 4000;
  localparam int unsigned SETTLE_TICKS = 4;
  localparam int unsigned HOLD_TICKS   = 600;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned TAIL_ITEMS   = 64;

  // Temperature segments and humidity scaling in Q8.24.
  localparam int unsigned T_ZERO_ABOVE = 188;
  localparam int unsigned T_SAT_BELOW  = 82;
  localparam int unsigned T_SAT_VALUE  = 46;
  localparam int unsigned T_SPLIT      = 104;
  localparam int unsigned T_HI_BASE    = 4608;
  localparam int unsigned T_HI_PIVOT   = 145;
  localparam int unsigned T_HI_SLOPE   = 104;
  localparam int unsigned T_LO_BASE    = 10522;
  localparam int unsigned T_LO_PIVOT   = 91;
  localparam int unsigned T_LO_SLOPE   = 125;
  localparam longint unsigned H_RECIP  = 64'd9235069;
  localparam longint unsigned H_OFFSET = 64'd74965378;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    swac_pkg::channel_e ch;
    logic [7:0]         avg;
    logic [7:0]         conv;
    logic               checked;
    logic               abn;
    swac_pkg::report_e  rpt;
  } window_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       action_i = 1'b0;
  logic       channel_i = 1'b0;
  logic [7:0] sample_i = '0;
  logic       quiet_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       which_channel_o;
  logic [7:0] average_o;
  logic [7:0] converted_o;
  logic       checked_o;
  logic       abnormal_o;
  logic [1:0] error_report_o;

  sensor_window_average_convert dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .channel_i      (channel_i),
    .sample_i       (sample_i),
    .quiet_i        (quiet_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .which_channel_o(which_channel_o),
    .average_o      (average_o),
    .converted_o    (converted_o),
    .checked_o      (checked_o),
    .abnormal_o     (abnormal_o),
    .error_report_o (error_report_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Model state, starting from the reset values of the block.
  logic [13:0] temp_sum_q = '0;
  logic [13:0] hum_sum_q = '0;
  logic [6:0]  temp_left_q = 7'(WINDOW_LEN);
  logic [6:0]  hum_left_q = 7'(WINDOW_LEN);
  logic        abnormal_q = 1'b0;
  logic [7:0]  temp_low_q = 8'd27;
  logic [7:0]  temp_high_q = 8'd245;
  logic [7:0]  hum_low_q = 8'd4;
  logic [7:0]  hum_high_q = 8'd204;

  window_result_t closed_windows_q[$];
  window_result_t oldest_window;

  int unsigned error_count = 0;
  int unsigned stuck_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  // Averages that sit on conversion breakpoints and limit edges.
  logic [7:0] level_marks [16] = '{8'd0, 8'd4, 8'd5, 8'd27, 8'd28, 8'd81, 8'd82, 8'd91,
                                   8'd104, 8'd105, 8'd145, 8'd188, 8'd189, 8'd204,
                                   8'd245, 8'd255};
  logic [7:0] level_by_ch [2] = '{8'd128, 8'd128};
  bit         flat_by_ch [2] = '{1'b1, 1'b1};

  function automatic logic [7:0] celsius_of(logic [7:0] avg);
    int unsigned base, slope, pivot, v;
    if (avg > T_ZERO_ABOVE) return 8'd0;
    if (avg < T_SAT_BELOW) return 8'(T_SAT_VALUE);
    if (avg > T_SPLIT) begin
      base = T_HI_BASE; slope = T_HI_SLOPE; pivot = T_HI_PIVOT;
    end else begin
      base = T_LO_BASE; slope = T_LO_SLOPE; pivot = T_LO_PIVOT;
    end
    if (avg > pivot) v = base - (int'(avg) - pivot) * slope;
    else v = base + (pivot - int'(avg)) * slope;
    return 8'((v + 128) >> 8);
  endfunction

  function automatic logic [7:0] humidity_of(logic [7:0] avg);
    longint unsigned acc;
    acc = longint'(avg) * H_RECIP + H_OFFSET;
    return 8'(acc >> 24);
  endfunction

  function automatic void average_windows(swac_pkg::action_e act, swac_pkg::channel_e ch,
                                          logic [7:0] smp, logic q);
    logic [13:0]    sum;
    logic [6:0]     left;
    logic [7:0]     lo, hi;
    window_result_t r;
    if (act == swac_pkg::ACT_RESTART) begin
      temp_sum_q = '0; temp_left_q = 7'(WINDOW_LEN);
      hum_sum_q = '0;  hum_left_q = 7'(WINDOW_LEN);
      return;
    end
    sum  = (ch == swac_pkg::CH_HUM) ? hum_sum_q : temp_sum_q;
    left = (ch == swac_pkg::CH_HUM) ? hum_left_q : temp_left_q;
    sum = sum + smp;
    if (left == 0 || left > WINDOW_LEN) left = 7'd1;
    left = left - 7'd1;
    if (left == 0) begin
      left = 7'(WINDOW_LEN);
      r.ch = ch;
      r.avg = sum[13:6];
      sum = '0;
      r.conv = (ch == swac_pkg::CH_HUM) ? humidity_of(r.avg) : celsius_of(r.avg);
      lo = (ch == swac_pkg::CH_HUM) ? hum_low_q : temp_low_q;
      hi = (ch == swac_pkg::CH_HUM) ? hum_high_q : temp_high_q;
      r.checked = !q;
      r.rpt = swac_pkg::RPT_NONE;
      if (!q) begin
        if (r.avg <= lo || r.avg >= hi) begin
          abnormal_q = 1'b1;
          r.rpt = swac_pkg::RPT_RAISE;
        end else begin
          if (abnormal_q) r.rpt = swac_pkg::RPT_CLEAR;
          abnormal_q = 1'b0;
        end
      end
      r.abn = abnormal_q;
      closed_windows_q.push_back(r);
    end
    if (ch == swac_pkg::CH_HUM) begin
      hum_sum_q = sum; hum_left_q = left;
    end else begin
      temp_sum_q = sum; temp_left_q = left;
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Results are checked before the request of the same edge is predicted; a window
  // result always belongs to a request accepted at an earlier edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (closed_windows_q.size() == 0) begin
          $error("unexpected result: channel %0d average %0d", which_channel_o, average_o);
          error_count++;
        end else begin
          oldest_window = closed_windows_q.pop_front();
          check_field("which_channel", 8'(oldest_window.ch), 8'(which_channel_o));
          check_field("average", oldest_window.avg, average_o);
          check_field("converted", oldest_window.conv, converted_o);
          check_field("checked", 8'(oldest_window.checked), 8'(checked_o));
          check_field("abnormal", 8'(oldest_window.abn), 8'(abnormal_o));
          check_field("error_report", 8'(oldest_window.rpt), 8'(error_report_o));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (swac_pkg::cfg_idx_e'(cfg_index_i))
          swac_pkg::CFG_TEMP_LOW:  temp_low_q = cfg_data_i;
          swac_pkg::CFG_TEMP_HIGH: temp_high_q = cfg_data_i;
          swac_pkg::CFG_HUM_LOW:   hum_low_q = cfg_data_i;
          swac_pkg::CFG_HUM_HIGH:  hum_high_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o)
        average_windows(swac_pkg::action_e'(action_i), swac_pkg::channel_e'(channel_i),
                        sample_i, quiet_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no request accepted for %0d cycles", stuck_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a long counted hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 87; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 87; end
      IDLE_BOTH:     begin send_idle_pct = 35; recv_stall_pct = 35; end
      default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // Valid stays high after acceptance until the next falling edge, where it either
  // carries the next request or drops for an idle gap.
  task automatic send_request(swac_pkg::action_e act, swac_pkg::channel_e ch,
                              logic [7:0] smp, logic q);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    action_i = act;
    channel_i = ch;
    sample_i = smp;
    quiet_i = q;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_for_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (closed_windows_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [7:0] t_lo, logic [7:0] t_hi, logic [7:0] h_lo,
                            logic [7:0] h_hi);
    logic [7:0] vals [4];
    vals = '{t_lo, t_hi, h_lo, h_hi};
    wait_for_idle();
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_valid_i = 1'b1;
      cfg_index_i = swac_pkg::cfg_idx_e'(i);
      cfg_data_i = vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Feeds one full window of a constant sample; only the closing sample's quiet
  // flag matters, so the others carry the opposite value.
  task automatic fill_window(swac_pkg::channel_e ch, logic [7:0] level, logic q);
    for (int i = 0; i < WINDOW_LEN; i++)
      send_request(swac_pkg::ACT_ADD, ch, level, (i == WINDOW_LEN - 1) ? q : !q);
  endtask

  task automatic pick_level(swac_pkg::channel_e ch);
    level_by_ch[ch] = $urandom_range(1) ? level_marks[$urandom_range(15)] : 8'($urandom);
    flat_by_ch[ch] = 1'($urandom_range(1));
  endtask

  // Samples cluster around a per-channel level, so window averages spread over the
  // whole range; flat channels send the level itself, except for 8 percent random samples.
  task automatic random_items(int unsigned count);
    swac_pkg::channel_e ch;
    logic [7:0]         smp;
    int                 s;
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(399) == 0) begin
        send_request(swac_pkg::ACT_RESTART, swac_pkg::channel_e'($urandom_range(1)),
                     8'($urandom), 1'($urandom_range(1)));
        continue;
      end
      ch = swac_pkg::channel_e'($urandom_range(1));
      if ($urandom_range(47) == 0) pick_level(ch);
      if ($urandom_range(99) < 8) begin
        smp = 8'($urandom);
      end else if (flat_by_ch[ch]) begin
        smp = level_by_ch[ch];
      end else begin
        s = int'(level_by_ch[ch]) + int'($urandom_range(16)) - 8;
        if (s < 0) s = 0;
        if (s > 255) s = 255;
        smp = 8'(s);
      end
      send_request(swac_pkg::ACT_ADD, ch, smp, $urandom_range(99) < 25);
    end
  endtask

  task automatic test_restart();
    for (int i = 0; i < 20; i++) send_request(swac_pkg::ACT_ADD, swac_pkg::CH_TEMP, 8'hff, 1'b0);
    for (int i = 0; i < 5; i++) send_request(swac_pkg::ACT_ADD, swac_pkg::CH_HUM, 8'hff, 1'b1);
    // Channel, sample and quiet are don't-cares on a restart.
    send_request(swac_pkg::ACT_RESTART, swac_pkg::CH_HUM, 8'ha5, 1'b1);
  endtask

  task automatic test_temp_windows();
    fill_window(swac_pkg::CH_TEMP, 8'd255, 1'b0);
    // A second out-of-range window raises the report again.
    fill_window(swac_pkg::CH_TEMP, 8'd0, 1'b0);
  endtask

  task automatic test_hum_windows();
    fill_window(swac_pkg::CH_HUM, 8'd255, 1'b1);
    fill_window(swac_pkg::CH_HUM, 8'd100, 1'b0);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_limits(8'd27, 8'd245, 8'd4, 8'd204);
        1: set_limits(8'd0, 8'd255, 8'd0, 8'd255);
        2: set_limits(8'd255, 8'd0, 8'd255, 8'd0);
        3: set_limits(8'd0, 8'd0, 8'd255, 8'd255);
        default: set_limits(level_marks[$urandom_range(15)], level_marks[$urandom_range(15)],
                            level_marks[$urandom_range(15)], level_marks[$urandom_range(15)]);
      endcase
      set_idling(idle_mode_e'(p % 4));
      random_items(PHASE_ITEMS);
    end
  endtask

  task automatic test_backpressure();
    set_limits(8'd60, 8'd200, 8'd40, 8'd180);
    set_idling(IDLE_NONE);
    hold_request = HOLD_TICKS;
    random_items(300);
  endtask

  task automatic test_long_run();
    set_idling(IDLE_BOTH);
    random_items(TAIL_ITEMS);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_restart();
    test_temp_windows();
    test_hum_windows();
    test_random_phases();
    test_backpressure();
    test_long_run();
    recv_stall_pct = 0;
    send_idle_pct = 0;
    wait_for_idle();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sensor_window_average_convert.f =====
hw/rtl/swac_pkg.sv
hw/rtl/swac_convert.sv
hw/rtl/sensor_window_average_convert.sv
test/tb.sv
